// ===== design/assert_macros.svh =====
// Assertion macros; clk and rst are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GDTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GDTP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDTP_ASSERT(label, prop, msg)
`define GDTP_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== design/gdtp_pkg.sv =====
package gdtp_pkg;

  localparam int MAX_HUB_SLICES_DEF = 63;

  localparam logic [1:0] CFG_SLICE_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_TASK_EDGES   = 2'd1;
  localparam logic [1:0] CFG_TASK_VERTS   = 2'd2;

  typedef enum logic [1:0] {
    KIND_TASK, KIND_SLICE, KIND_SUMMARY, KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_OVERFLOW, ERR_SLICES, ERR_FINISHED, ERR_POISONED, ERR_CONFIG
  } err_t;

  typedef enum logic [1:0] {
    RUN_ACTIVE, RUN_FINISHED, RUN_POISONED
  } run_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_COUNT, ST_HUB_FLUSH, ST_SLICE, ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic latch;
    logic emit_err;
    err_t err_code;
    logic poison;
    logic emit_flush;
    logic emit_summary;
    logic light;
    logic cnt_init;
    logic cnt_step;
    logic slice_emit;
  } cmd_t;

  typedef struct packed {
    run_t run;
    logic cfg_bad;
    logic is_finish;
    logic overflow;
    logic is_hub;
    logic open_valid;
    logic cnt_more;
    logic cnt_full;
    logic slice_last;
    logic out_free;
  } stat_t;

endpackage

// ===== design/gdtp_ctrl.sv =====
module gdtp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gdtp_pkg::stat_t st,
  output gdtp_pkg::cmd_t  cmd
);
  import gdtp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.err_code = ERR_NONE;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
          if (st.run == RUN_FINISHED) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = ERR_FINISHED;
          end else if (st.run != RUN_ACTIVE) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = ERR_POISONED;
          end else if (st.cfg_bad) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = ERR_CONFIG;
          end else if (st.is_finish) begin
            if (st.open_valid) begin
              cmd.emit_flush = 1'b1;
              state_next = ST_SUMMARY;
            end else begin
              cmd.emit_summary = 1'b1;
            end
          end else if (st.overflow) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = ERR_OVERFLOW;
            cmd.poison = 1'b1;
          end else if (st.is_hub) begin
            cmd.cnt_init = 1'b1;
            state_next = ST_COUNT;
          end else begin
            cmd.light = 1'b1;
          end
        end
      end
      ST_COUNT: begin
        if (!st.cnt_more) begin
          state_next = ST_HUB_FLUSH;
        end else if (!st.cnt_full) begin
          cmd.cnt_step = 1'b1;
        end else if (st.out_free) begin
          cmd.emit_err = 1'b1;
          cmd.err_code = ERR_SLICES;
          cmd.poison = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_HUB_FLUSH: begin
        if (st.out_free) begin
          cmd.emit_flush = st.open_valid;
          state_next = ST_SLICE;
        end
      end
      ST_SLICE: begin
        if (st.out_free) begin
          cmd.slice_emit = 1'b1;
          if (st.slice_last) state_next = ST_IDLE;
        end
      end
      ST_SUMMARY: begin
        if (st.out_free) begin
          cmd.emit_summary = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== design/gdtp_dp.sv =====
module gdtp_dp #(
  parameter int MAX_HUB_SLICES = gdtp_pkg::MAX_HUB_SLICES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [47:0]     cfg_data,
  input  logic            in_command,
  input  logic [31:0]     in_count,
  input  gdtp_pkg::cmd_t  cmd,
  output gdtp_pkg::stat_t st,
  output logic            out_valid,
  input  logic            out_ready,
  output gdtp_pkg::kind_t out_kind,
  output logic [31:0]     out_first_destination,
  output logic [31:0]     out_destination_span,
  output logic [63:0]     out_edge_start,
  output logic [63:0]     out_edge_span,
  output logic [5:0]      out_slice_number,
  output logic [5:0]      out_slice_total,
  output logic [63:0]     out_tasks_emitted,
  output gdtp_pkg::err_t  out_error_code,
  output logic            out_last
);
  import gdtp_pkg::*;

  logic [31:0] slice_limit, task_verts;
  logic [47:0] task_edges;
  logic        cur_command;
  logic [31:0] cur_count;
  logic        open_valid;
  logic [31:0] open_first, open_span;
  logic [63:0] open_start;
  logic [47:0] open_edges;
  logic [31:0] dest_seen;
  logic [63:0] edges_seen, task_cnt;
  run_t        run;
  logic [31:0] rest, srem;
  logic [5:0]  nslices, sidx;
  logic [63:0] sstart;
  logic        out_free, light_close, advance;
  logic [31:0] slice_n;

  assign out_free = !out_valid || out_ready;
  assign light_close = open_valid && (open_span >= task_verts ||
                       ({1'b0, open_edges} + {17'd0, cur_count}) > {1'b0, task_edges});
  assign slice_n = (srem < slice_limit) ? srem : slice_limit;
  assign advance = cmd.light || (cmd.slice_emit && srem <= slice_limit);

  always_comb begin
    st.run        = run;
    st.cfg_bad    = slice_limit == '0 || task_edges == '0 || task_verts == '0 ||
                    {16'd0, slice_limit} > task_edges;
    st.is_finish  = cur_command;
    st.overflow   = dest_seen == '1 || {32'd0, cur_count} > ~edges_seen;
    st.is_hub     = cur_count > slice_limit;
    st.open_valid = open_valid;
    st.cnt_more   = rest > slice_limit;
    st.cnt_full   = nslices == 6'(MAX_HUB_SLICES);
    st.slice_last = srem <= slice_limit;
    st.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_limit <= 32'd1024;
      task_edges  <= 48'd65536;
      task_verts  <= 32'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLICE_LIMIT: slice_limit <= cfg_data[31:0];
        CFG_TASK_EDGES:  task_edges  <= cfg_data;
        CFG_TASK_VERTS:  task_verts  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_command <= in_command;
      cur_count   <= in_count;
    end
    if (cmd.cnt_init) begin
      rest    <= cur_count;
      nslices <= 6'd1;
      srem    <= cur_count;
      sidx    <= '0;
      sstart  <= edges_seen;
    end else if (cmd.cnt_step) begin
      rest    <= rest - slice_limit;
      nslices <= nslices + 6'd1;
    end else if (cmd.slice_emit) begin
      srem   <= srem - slice_n;
      sidx   <= sidx + 6'd1;
      sstart <= sstart + {32'd0, slice_n};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_valid <= 1'b0;
      open_first <= '0;
      open_span  <= '0;
      open_start <= '0;
      open_edges <= '0;
      dest_seen  <= '0;
      edges_seen <= '0;
      task_cnt   <= '0;
      run        <= RUN_ACTIVE;
    end else begin
      if (cmd.poison) run <= RUN_POISONED;
      if (cmd.emit_summary) run <= RUN_FINISHED;
      if (cmd.emit_flush || (cmd.light && light_close) || cmd.slice_emit)
        task_cnt <= task_cnt + 64'd1;
      if (cmd.emit_flush) begin
        open_valid <= 1'b0;
        open_span  <= '0;
        open_edges <= '0;
      end
      if (cmd.light) begin
        open_valid <= 1'b1;
        if (!open_valid || light_close) begin
          open_first <= dest_seen;
          open_start <= edges_seen;
          open_span  <= 32'd1;
          open_edges <= {16'd0, cur_count};
        end else begin
          open_span  <= open_span + 32'd1;
          open_edges <= open_edges + {16'd0, cur_count};
        end
      end
      if (advance) begin
        dest_seen  <= dest_seen + 32'd1;
        edges_seen <= edges_seen + {32'd0, cur_count};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_err || cmd.emit_flush || cmd.emit_summary || cmd.slice_emit ||
                 (cmd.light && light_close)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_kind              <= KIND_ERROR;
      out_first_destination <= '0;
      out_destination_span  <= '0;
      out_edge_start        <= '0;
      out_edge_span         <= '0;
      out_slice_number      <= '0;
      out_slice_total       <= '0;
      out_tasks_emitted     <= task_cnt;
      out_error_code        <= cmd.err_code;
      out_last              <= 1'b1;
    end else if (cmd.emit_flush || (cmd.light && light_close)) begin
      out_kind              <= KIND_TASK;
      out_first_destination <= open_first;
      out_destination_span  <= open_span;
      out_edge_start        <= open_start;
      out_edge_span         <= {16'd0, open_edges};
      out_slice_number      <= '0;
      out_slice_total       <= '0;
      out_tasks_emitted     <= task_cnt + 64'd1;
      out_error_code        <= ERR_NONE;
      out_last              <= cmd.light;
    end else if (cmd.emit_summary) begin
      out_kind              <= KIND_SUMMARY;
      out_first_destination <= '0;
      out_destination_span  <= dest_seen;
      out_edge_start        <= '0;
      out_edge_span         <= edges_seen;
      out_slice_number      <= '0;
      out_slice_total       <= '0;
      out_tasks_emitted     <= task_cnt;
      out_error_code        <= ERR_NONE;
      out_last              <= 1'b1;
    end else if (cmd.slice_emit) begin
      out_kind              <= KIND_SLICE;
      out_first_destination <= dest_seen;
      out_destination_span  <= 32'd1;
      out_edge_start        <= sstart;
      out_edge_span         <= {32'd0, slice_n};
      out_slice_number      <= sidx;
      out_slice_total       <= nslices;
      out_tasks_emitted     <= task_cnt + 64'd1;
      out_error_code        <= ERR_NONE;
      out_last              <= srem <= slice_limit;
    end
  end

endmodule

// ===== design/graph_degree_task_partitioner.sv =====
// Degree-driven task partitioner.
// Input stream: s_axis_tdata carries an incoming edge count, s_axis_tuser the
// command (0 count, 1 finish). Output stream: one item per task, hub slice,
// summary or error; m_axis_tuser is the kind, m_axis_tlast marks the final
// item caused by one input item. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// An input item is accepted only while the controller is idle; it is latched
// and then decided once the output register is free. A hub destination with
// S slices steps through the slice counter (S - 1 subtractions and one step
// to leave), flushes any open task, then emits one slice per cycle while the
// output is free; finish flushes it too. Each emitted item needs a free output
// register, so a stalled receiver holds the controller in place; the output
// register lets one result wait while the next item is accepted.
// Reset (synchronous, active high) restores the register defaults 1024,
// 65536 and 256, clears the destination, edge and task counters and the
// open task, and empties the output register.
module graph_degree_task_partitioner #(
  parameter int MAX_HUB_SLICES = gdtp_pkg::MAX_HUB_SLICES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // edge count of the next destination
  input  logic         s_axis_tuser,   // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // first_destination, destination_span, edge_start, edge_span,
  // slice_number, slice_total, tasks_emitted, error_code, zero pad
  output logic [271:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast
);
  import gdtp_pkg::*;

  `include "assert_macros.svh"

  cmd_t  cmd;
  stat_t st;
  kind_t kind;
  err_t  err_code;
  logic [31:0] first_destination, destination_span;
  logic [63:0] edge_start, edge_span, tasks_emitted;
  logic [5:0]  slice_number, slice_total;

  gdtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gdtp_dp #(.MAX_HUB_SLICES(MAX_HUB_SLICES)) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_command            (s_axis_tuser),
    .in_count              (s_axis_tdata),
    .cmd                   (cmd),
    .st                    (st),
    .out_valid             (m_axis_tvalid),
    .out_ready             (m_axis_tready),
    .out_kind              (kind),
    .out_first_destination (first_destination),
    .out_destination_span  (destination_span),
    .out_edge_start        (edge_start),
    .out_edge_span         (edge_span),
    .out_slice_number      (slice_number),
    .out_slice_total       (slice_total),
    .out_tasks_emitted     (tasks_emitted),
    .out_error_code        (err_code),
    .out_last              (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {1'b0, err_code, tasks_emitted, slice_total, slice_number,
                         edge_span, edge_start, destination_span, first_destination};

  `GDTP_ASSERT_RST(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")
  `GDTP_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
    "input accepted while deciding")
  `GDTP_ASSERT(a_error_last, m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tlast,
    "error item not last")
  `GDTP_ASSERT(a_slice_index, m_axis_tvalid && m_axis_tuser == KIND_SLICE |->
    m_axis_tdata[197:192] < m_axis_tdata[203:198], "slice index beyond total")

endmodule

// ===== bench/graph_degree_task_partitioner_tb.sv =====
`timescale 1ns / 1ps

module graph_degree_task_partitioner_tb;
  import gdtp_pkg::*;

  typedef struct {
    kind_t        kind;
    logic [31:0]  first_dst;
    logic [31:0]  dst_span;
    logic [63:0]  edge_start;
    logic [63:0]  edge_span;
    logic [5:0]   slice_num;
    logic [5:0]   slice_total;
    logic [63:0]  tasks_emitted;
    err_t         err;
    logic         last;
  } task_item_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [47:0] value;
    bit          cmd;
    bit          chk;
    kind_t       kind;
    err_t        err;
  } step_t;

  localparam int NUM_DIRECTED = 27;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 20;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = CFG_SLICE_LIMIT;
  logic [47:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [271:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  graph_degree_task_partitioner i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  task_item_t expected_tasks[$];
  bit failed = 1'b0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  logic [31:0] slice_limit;
  logic [47:0] task_edge_limit;
  logic [31:0] task_vertex_limit;
  logic        open_valid;
  logic [31:0] open_first;
  logic [31:0] open_dsts;
  logic [63:0] open_start;
  logic [47:0] open_edges;
  logic [31:0] dsts_seen;
  logic [63:0] edges_seen;
  logic [63:0] tasks_done;
  run_t        run_state;

  step_t directed_steps [0:NUM_DIRECTED-1] = '{
    '{0, CFG_SLICE_LIMIT, 48'd0,          0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd1024,       0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd1025,       0, 1, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd64512,      0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd1,          0, 0, KIND_TASK,  ERR_NONE},
    '{1, CFG_TASK_VERTS,  48'd1,          0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd5,          0, 1, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd6,          0, 0, KIND_TASK,  ERR_NONE},
    '{1, CFG_SLICE_LIMIT, 48'd0,          0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd7,          0, 1, KIND_ERROR, ERR_CONFIG},
    '{1, CFG_SLICE_LIMIT, 48'd2000,       0, 0, KIND_TASK,  ERR_NONE},
    '{1, CFG_TASK_EDGES,  48'd1000,       0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd7,          0, 1, KIND_ERROR, ERR_CONFIG},
    '{1, CFG_SLICE_LIMIT, 48'd1,          0, 0, KIND_TASK,  ERR_NONE},
    '{1, CFG_TASK_EDGES,  48'd0,          0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd7,          0, 1, KIND_ERROR, ERR_CONFIG},
    '{1, CFG_TASK_EDGES,  48'hFFFF_FFFF_FFFF, 0, 0, KIND_TASK, ERR_NONE},
    '{1, CFG_SLICE_LIMIT, 48'hFFFF_FFFF,  0, 0, KIND_TASK,  ERR_NONE},
    '{1, CFG_TASK_VERTS,  48'hFFFF_FFFF,  0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'hFFFF_FFFF,  0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'hFFFF_FFFF,  0, 0, KIND_TASK,  ERR_NONE},
    '{1, CFG_TASK_VERTS,  48'd0,          0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd3,          0, 1, KIND_ERROR, ERR_CONFIG},
    '{1, CFG_TASK_VERTS,  48'd2,          0, 0, KIND_TASK,  ERR_NONE},
    '{1, CFG_SLICE_LIMIT, 48'd68174085,   0, 0, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'hFFFF_FFFF,  0, 1, KIND_TASK,  ERR_NONE},
    '{0, CFG_SLICE_LIMIT, 48'd0,          0, 0, KIND_TASK,  ERR_NONE}
  };

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void push_result(kind_t kind, logic [31:0] fd, logic [31:0] ds,
                                      logic [63:0] es, logic [63:0] en, logic [5:0] sn,
                                      logic [5:0] st, logic [63:0] te, err_t err);
    task_item_t r;
    r.kind = kind;
    r.first_dst = fd;
    r.dst_span = ds;
    r.edge_start = es;
    r.edge_span = en;
    r.slice_num = sn;
    r.slice_total = st;
    r.tasks_emitted = te;
    r.err = err;
    r.last = 1'b0;
    expected_tasks.insert(expected_tasks.size(), r);
  endfunction

  function automatic void close_open_task();
    if (open_valid) begin
      tasks_done++;
      push_result(KIND_TASK, open_first, open_dsts, open_start, 64'(open_edges), '0, '0,
                  tasks_done, ERR_NONE);
      open_valid = 1'b0;
      open_dsts = '0;
      open_edges = '0;
    end
  endfunction

  function automatic void predict_partition(bit cmd, logic [31:0] count);
    int          base;
    logic [63:0] n_slices;
    logic [63:0] done;
    logic [63:0] rest;
    logic [63:0] n;
    base = expected_tasks.size();
    if (run_state == RUN_FINISHED) begin
      push_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, tasks_done, ERR_FINISHED);
    end else if (run_state != RUN_ACTIVE) begin
      push_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, tasks_done, ERR_POISONED);
    end else if (slice_limit == 0 || task_edge_limit == 0 || task_vertex_limit == 0 ||
                 48'(slice_limit) > task_edge_limit) begin
      push_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, tasks_done, ERR_CONFIG);
    end else if (cmd) begin
      close_open_task();
      push_result(KIND_SUMMARY, '0, dsts_seen, '0, edges_seen, '0, '0, tasks_done, ERR_NONE);
      run_state = RUN_FINISHED;
    end else if (dsts_seen == 32'hFFFF_FFFF ||
                 (65'(edges_seen) + 65'(count)) > 65'h0_FFFF_FFFF_FFFF_FFFF) begin
      run_state = RUN_POISONED;
      push_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, tasks_done, ERR_OVERFLOW);
    end else if (count > slice_limit) begin
      n_slices = (64'(count) + 64'(slice_limit) - 1) / 64'(slice_limit);
      if (n_slices > 63) begin
        run_state = RUN_POISONED;
        open_valid = 1'b0;
        push_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, tasks_done, ERR_SLICES);
      end else begin
        close_open_task();
        done = '0;
        for (int i = 0; i < int'(n_slices); i++) begin
          rest = 64'(count) - done;
          n = (rest < 64'(slice_limit)) ? rest : 64'(slice_limit);
          tasks_done++;
          push_result(KIND_SLICE, dsts_seen, 32'd1, edges_seen + done, n, 6'(i),
                      6'(n_slices), tasks_done, ERR_NONE);
          done += n;
        end
        edges_seen += 64'(count);
        dsts_seen++;
      end
    end else begin
      if (open_valid && (open_dsts >= task_vertex_limit ||
                         (49'(open_edges) + 49'(count)) > 49'(task_edge_limit)))
        close_open_task();
      if (!open_valid) begin
        open_valid = 1'b1;
        open_first = dsts_seen;
        open_dsts = '0;
        open_start = edges_seen;
        open_edges = '0;
      end
      open_dsts++;
      open_edges = open_edges + 48'(count);
      edges_seen += 64'(count);
      dsts_seen++;
    end
    if (expected_tasks.size() > base)
      expected_tasks[expected_tasks.size() - 1].last = 1'b1;
  endfunction

  task automatic send_item(bit cmd, logic [31:0] count, bit chk, kind_t kind, err_t err);
    int gap;
    int base;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= count;
    s_axis_tuser <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    base = expected_tasks.size();
    predict_partition(cmd, count);
    if (chk && (expected_tasks[base].kind != kind || expected_tasks[base].err != err)) begin
      $error("directed kind/error_code: expected %0d/%0d, predicted %0d/%0d",
             kind, err, expected_tasks[base].kind, expected_tasks[base].err);
      failed = 1'b1;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    wait (expected_tasks.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SLICE_LIMIT: slice_limit = value[31:0];
      CFG_TASK_EDGES:  task_edge_limit = value;
      CFG_TASK_VERTS:  task_vertex_limit = value[31:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_count();
    logic [63:0] lo;
    logic [63:0] hi;
    int          n;
    case ($urandom_range(0, 19))
      0: begin
        hi = 64'd63 * 64'(slice_limit);
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return $urandom_range(hi[31:0], 0);
      end
      1: return slice_limit;
      2, 3, 4, 5, 6: begin
        n = $urandom_range(2, 63);
        lo = 64'(n - 1) * 64'(slice_limit) + 1;
        hi = 64'(n) * 64'(slice_limit);
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        if (lo > hi) return $urandom_range(0, slice_limit);
        return $urandom_range(hi[31:0], lo[31:0]);
      end
      default: return $urandom_range(0, slice_limit);
    endcase
  endfunction

  // receiver
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act);
    if (exp_val !== act) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    task_item_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_tasks.size() == 0) begin
        $error("unexpected item: kind %0d", m_axis_tuser);
        failed = 1'b1;
      end else begin
        e = expected_tasks.pop_front();
        check_field("kind", 64'(e.kind), 64'(m_axis_tuser));
        check_field("first_destination", 64'(e.first_dst), 64'(m_axis_tdata[31:0]));
        check_field("destination_span", 64'(e.dst_span), 64'(m_axis_tdata[63:32]));
        check_field("edge_start", e.edge_start, m_axis_tdata[127:64]);
        check_field("edge_span", e.edge_span, m_axis_tdata[191:128]);
        check_field("slice_number", 64'(e.slice_num), 64'(m_axis_tdata[197:192]));
        check_field("slice_total", 64'(e.slice_total), 64'(m_axis_tdata[203:198]));
        check_field("tasks_emitted", e.tasks_emitted, m_axis_tdata[267:204]);
        check_field("error_code", 64'(e.err), 64'(m_axis_tdata[270:268]));
        check_field("last", 64'(e.last), 64'(m_axis_tlast));
      end
    end
  end

  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!s_axis_tvalid && expected_tasks.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    slice_limit = 32'd1024;
    task_edge_limit = 48'd65536;
    task_vertex_limit = 32'd256;
    open_valid = 1'b0;
    open_first = '0;
    open_dsts = '0;
    open_start = '0;
    open_edges = '0;
    dsts_seen = '0;
    edges_seen = '0;
    tasks_done = '0;
    run_state = RUN_ACTIVE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        wait_idle();
        write_reg(directed_steps[i].idx, directed_steps[i].value);
      end else begin
        send_item(directed_steps[i].cmd, directed_steps[i].value[31:0],
                  directed_steps[i].chk, directed_steps[i].kind, directed_steps[i].err);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      logic [31:0] s;
      wait_idle();
      case ($urandom_range(0, 4))
        0: s = 32'd1;
        1: s = $urandom_range(1, 16);
        2: s = $urandom_range(100, 5000);
        default: s = $urandom_range(1, 100000);
      endcase
      if (ph == 5) begin
        write_reg(CFG_TASK_EDGES, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_SLICE_LIMIT, 48'($urandom_range(1, 300000)));
        write_reg(CFG_TASK_VERTS, 48'hFFFF_FFFF);
      end else begin
        write_reg(CFG_TASK_EDGES, 48'(s) + 48'($urandom_range(0, 4 * s)));
        write_reg(CFG_SLICE_LIMIT, 48'(s));
        write_reg(CFG_TASK_VERTS,
                  48'($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(1, 300)));
      end
      no_gaps = (ph == 3);
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < 50; k++)
        send_item(1'b0, pick_count(), 1'b0, KIND_TASK, ERR_NONE);
    end

    no_gaps = 1'b0;
    if ($urandom_range(0, 1)) begin
      send_item(1'b1, $urandom(), 1'b0, KIND_TASK, ERR_NONE);
      send_item(1'b0, 32'd5, 1'b1, KIND_ERROR, ERR_FINISHED);
      send_item(1'b1, 32'd0, 1'b1, KIND_ERROR, ERR_FINISHED);
      send_item(1'b0, 32'hFFFF_FFFF, 1'b1, KIND_ERROR, ERR_FINISHED);
    end else begin
      wait_idle();
      write_reg(CFG_SLICE_LIMIT, 48'd1);
      send_item(1'b0, 32'd64, 1'b1, KIND_ERROR, ERR_SLICES);
      send_item(1'b1, 32'd0, 1'b1, KIND_ERROR, ERR_POISONED);
      send_item(1'b0, 32'd3, 1'b1, KIND_ERROR, ERR_POISONED);
    end

    s_axis_tvalid <= 1'b0;
    wait (expected_tasks.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_tasks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
